// ----- sv/nearest_observation_table_assert.svh -----
// ============================================================================
// Assertion macros for the nearest observation table
// Shared property templates used by the top level.
// ============================================================================
`ifndef NEAREST_OBSERVATION_TABLE_ASSERT_SVH
`define NEAREST_OBSERVATION_TABLE_ASSERT_SVH

// implication checked in the next cycle
`define NOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the same cycle
`define NOT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/not_pkg.sv -----
// ============================================================================
// Nearest observation table package
// Word types, entry layout, codes and command/status bundles.
// ============================================================================
`default_nettype none

package not_pkg;

    localparam int TableDepthDefault = 2048;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] ST_REREP   = 3'd0;
    localparam logic [2:0] ST_MARKED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_APPEND  = 3'd3;
    localparam logic [2:0] ST_FOUND   = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    localparam logic [15:0] MIN_DISTANCE_CM = 16'd10;
    localparam logic signed [32:0] SAME_NODE_WINDOW_S  = 33'sd30;
    localparam logic signed [32:0] OTHER_NODE_WINDOW_S = 33'sd120;

    typedef struct packed {
        logic [1:0]        op;
        logic [47:0]       device_mac;
        logic [5:0]        node_id;
        logic [31:0]       first_seen;
        logic [31:0]       last_seen;
        logic [15:0]       distance_cm;
        logic signed [7:0] device_class;
        logic [47:0]       replaced_by;
        logic [15:0]       hit_count;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  best_node;
        logic [15:0] best_distance_cm;
        logic [31:0] best_time;
    } t_out_word;

    typedef struct packed {
        logic [47:0] mac;
        logic [5:0]  node;
        logic [15:0] distance;
        logic [7:0]  cls;
        logic [47:0] replaced;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [15:0] count;
    } t_entry;

    typedef enum logic [1:0] {J_HOLD, J_TOP, J_ZERO, J_DEC} t_j_op;
    typedef enum logic [1:0] {J2_NONE, J2_INC} t_j_inc;
    typedef enum logic [1:0] {K_HOLD, K_ZERO, K_FROM_J, K_INC} t_k_op;
    typedef enum logic [1:0] {F_HOLD, F_INC, F_DEC} t_fill_op;
    typedef enum logic [2:0] {WS_NONE, WS_REP, WS_SHIFT, WS_NEW, WS_BEST} t_wsel;

    typedef struct packed {
        logic       ld_in;
        t_j_op      j_op;
        logic       j_inc;
        t_k_op      k_op;
        logic       rd_en;
        logic       rd_k;
        t_wsel      wsel;
        t_fill_op   fill_op;
        logic       q_clr;
        logic       q_eval;
        logic       out_ld;
        logic [2:0] out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       mn_hit;
        logic       rr_hit;
        logic       mac_hit;
        logic       q_tight;
        logic       found;
        logic       j_zero;
        logic       j_last;
        logic       k_last;
        logic       fill_zero;
        logic       fill_full;
        logic       rb_zero;
        logic       short_dist;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- sv/not_datapath.sv -----
// ============================================================================
// Nearest observation table datapath
// Entry memory, scan and shift indexes, best-match registers, result word.
// ============================================================================
`default_nettype none

module not_datapath #(
    parameter int TABLE_DEPTH = not_pkg::TableDepthDefault
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  not_pkg::t_dp_cmd   i_cmd,
    output not_pkg::t_dp_stat  o_stat,
    input  not_pkg::t_in_word  i_word,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output not_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = $bits(not_pkg::t_entry);

    logic [EW-1:0] mem [TABLE_DEPTH];

    not_pkg::t_in_word  r_in;
    not_pkg::t_entry    r_rd;
    not_pkg::t_entry    r_best;
    not_pkg::t_out_word r_out;
    logic [AW:0]   r_fill;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_k;
    logic [AW-1:0] r_best_idx;
    logic          r_found;
    logic          r_out_valid;

    not_pkg::t_entry  w_new;
    not_pkg::t_entry  w_wdata;
    logic [AW-1:0]    w_waddr;
    logic             w_we;
    logic [AW-1:0]    w_raddr;
    logic [AW:0]      w_fill_m1;
    logic signed [32:0] w_dt;
    logic             w_same;
    logic             w_nearer;
    logic             w_take;
    logic             w_out_free;

    assign w_new = '{mac: r_in.device_mac, node: r_in.node_id, distance: r_in.distance_cm,
                     cls: r_in.device_class, replaced: r_in.replaced_by,
                     first_time: r_in.first_seen, last_time: r_in.last_seen,
                     count: r_in.hit_count};
    assign w_fill_m1 = r_fill - 1'b1;
    assign w_raddr   = i_cmd.rd_k ? r_k + 1'b1 : r_j;
    assign w_dt      = $signed({1'b0, r_best.last_time}) - $signed({1'b0, r_rd.last_time});
    assign w_same    = (r_best.node == r_rd.node);
    assign w_nearer  = (r_best.distance > r_rd.distance);
    assign w_take    = o_stat.mac_hit && r_found && !w_same && w_nearer
                       && (w_dt < not_pkg::OTHER_NODE_WINDOW_S);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_j;
        w_wdata = r_rd;
        unique case (i_cmd.wsel)
            not_pkg::WS_REP: begin
                w_wdata.replaced = r_in.replaced_by;
            end
            not_pkg::WS_SHIFT: begin
                w_waddr = r_k;
            end
            not_pkg::WS_NEW: begin
                w_waddr = r_fill[AW-1:0];
                w_wdata = w_new;
            end
            not_pkg::WS_BEST: begin
                w_waddr = r_best_idx;
                w_wdata = r_best;
                w_wdata.distance = r_rd.distance;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.op         = r_in.op;
        o_stat.mn_hit     = (r_rd.mac == r_in.device_mac) && (r_rd.node == r_in.node_id);
        o_stat.rr_hit     = o_stat.mn_hit && (r_rd.replaced != r_in.replaced_by)
                            && (r_rd.last_time == r_in.last_seen);
        o_stat.mac_hit    = (r_rd.mac == r_in.device_mac);
        o_stat.q_tight    = o_stat.mac_hit && r_found && w_same && w_nearer
                            && (w_dt < not_pkg::SAME_NODE_WINDOW_S);
        o_stat.found      = r_found;
        o_stat.j_zero     = (r_j == '0);
        o_stat.j_last     = ({1'b0, r_j} == w_fill_m1);
        o_stat.k_last     = ({1'b0, r_k} + 1'b1 == w_fill_m1);
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.fill_full  = (r_fill == (AW+1)'(TABLE_DEPTH));
        o_stat.rb_zero    = (r_in.replaced_by == '0);
        o_stat.short_dist = (r_in.distance_cm < not_pkg::MIN_DISTANCE_CM);
        o_stat.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in <= i_word;
        end
        unique case (i_cmd.j_op)
            not_pkg::J_TOP:  r_j <= w_fill_m1[AW-1:0];
            not_pkg::J_ZERO: r_j <= '0;
            not_pkg::J_DEC:  r_j <= r_j - 1'b1;
            default: begin
                if (i_cmd.j_inc) begin
                    r_j <= r_j + 1'b1;
                end
            end
        endcase
        unique case (i_cmd.k_op)
            not_pkg::K_ZERO:   r_k <= '0;
            not_pkg::K_FROM_J: r_k <= r_j;
            not_pkg::K_INC:    r_k <= r_k + 1'b1;
            default:           r_k <= r_k;
        endcase
        if (i_cmd.q_eval) begin
            if ((o_stat.mac_hit && !r_found) || w_take) begin
                r_best     <= r_rd;
                r_best_idx <= r_j;
            end else if (o_stat.q_tight) begin
                r_best.distance <= r_rd.distance;
            end
        end
        if (i_cmd.out_ld && w_out_free) begin
            r_out.status <= i_cmd.out_status;
            if (i_cmd.out_status == not_pkg::ST_FOUND) begin
                r_out.best_node        <= r_best.node;
                r_out.best_distance_cm <= r_best.distance;
                r_out.best_time        <= r_best.last_time;
            end else begin
                r_out.best_node        <= '0;
                r_out.best_distance_cm <= '0;
                r_out.best_time        <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.fill_op)
                not_pkg::F_INC: r_fill <= r_fill + 1'b1;
                not_pkg::F_DEC: r_fill <= r_fill - 1'b1;
                default:        r_fill <= r_fill;
            endcase
            if (i_cmd.q_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.q_eval && o_stat.mac_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_ld && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- sv/not_control.sv -----
// ============================================================================
// Nearest observation table controller
// Sequences re-report, mark, evict, append, duplicate removal and query scans.
// ============================================================================
`default_nettype none

module not_control (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  not_pkg::t_dp_stat i_stat,
    output not_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RR_RD, S_RR_EV, S_ADD_CHK, S_MK_RD, S_MK_EV,
        S_EV_RD, S_EV_EV, S_APPEND, S_DP_RD, S_DP_EV, S_RM_RD, S_RM_EV,
        S_Q_RD, S_Q_EV
    } t_state;

    typedef enum logic [0:0] {P_WORK, P_FIN} t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [2:0] r_status, n_status;

    assign o_in_ready = (r_phase == P_WORK) && (r_state == S_IDLE);

    always_comb begin
        o_cmd = '{ld_in: 1'b0, j_op: not_pkg::J_HOLD, j_inc: 1'b0, k_op: not_pkg::K_HOLD,
                  rd_en: 1'b0, rd_k: 1'b0, wsel: not_pkg::WS_NONE,
                  fill_op: not_pkg::F_HOLD, q_clr: 1'b0, q_eval: 1'b0,
                  out_ld: 1'b0, out_status: r_status};
        n_state  = r_state;
        n_phase  = r_phase;
        n_status = r_status;
        if (r_phase == P_FIN) begin
            o_cmd.out_ld = 1'b1;
            if (i_stat.out_free) begin
                n_phase = P_WORK;
                n_state = S_IDLE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    o_cmd.ld_in = i_in_valid;
                    if (i_in_valid) n_state = S_DISPATCH;
                end
                S_DISPATCH: begin
                    o_cmd.q_clr = 1'b1;
                    priority if (i_stat.op == not_pkg::OP_ADD) begin
                        if (i_stat.fill_zero) begin
                            n_state = S_ADD_CHK;
                        end else begin
                            o_cmd.j_op = not_pkg::J_TOP;
                            n_state = S_RR_RD;
                        end
                    end else if (i_stat.op == not_pkg::OP_MARK) begin
                        if (i_stat.rb_zero || i_stat.fill_zero) begin
                            n_status = not_pkg::ST_MARKED;
                            n_phase  = P_FIN;
                        end else begin
                            o_cmd.j_op = not_pkg::J_ZERO;
                            n_state = S_MK_RD;
                        end
                    end else if (i_stat.op == not_pkg::OP_QUERY) begin
                        if (i_stat.fill_zero) begin
                            n_status = not_pkg::ST_NONE;
                            n_phase  = P_FIN;
                        end else begin
                            o_cmd.j_op = not_pkg::J_TOP;
                            n_state = S_Q_RD;
                        end
                    end else begin
                        n_status = not_pkg::ST_NONE;
                        n_phase  = P_FIN;
                    end
                end
                S_RR_RD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RR_EV;
                end
                S_RR_EV: begin
                    priority if (i_stat.rr_hit) begin
                        o_cmd.wsel = not_pkg::WS_REP;
                        n_status = not_pkg::ST_REREP;
                        n_phase  = P_FIN;
                    end else if (i_stat.j_zero) begin
                        n_state = S_ADD_CHK;
                    end else begin
                        o_cmd.j_op = not_pkg::J_DEC;
                        n_state = S_RR_RD;
                    end
                end
                S_ADD_CHK: begin
                    priority if (!i_stat.rb_zero) begin
                        if (i_stat.fill_zero) begin
                            n_status = not_pkg::ST_MARKED;
                            n_phase  = P_FIN;
                        end else begin
                            o_cmd.j_op = not_pkg::J_ZERO;
                            n_state = S_MK_RD;
                        end
                    end else if (i_stat.short_dist) begin
                        n_status = not_pkg::ST_DROPPED;
                        n_phase  = P_FIN;
                    end else if (i_stat.fill_full) begin
                        o_cmd.k_op = not_pkg::K_ZERO;
                        n_state = S_EV_RD;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
                S_MK_RD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_MK_EV;
                end
                S_MK_EV: begin
                    if (i_stat.mn_hit) o_cmd.wsel = not_pkg::WS_REP;
                    if (i_stat.j_last) begin
                        n_status = not_pkg::ST_MARKED;
                        n_phase  = P_FIN;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state = S_MK_RD;
                    end
                end
                S_EV_RD: begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_k  = 1'b1;
                    n_state = S_EV_EV;
                end
                S_EV_EV: begin
                    o_cmd.wsel = not_pkg::WS_SHIFT;
                    if (i_stat.k_last) begin
                        o_cmd.fill_op = not_pkg::F_DEC;
                        n_state = S_APPEND;
                    end else begin
                        o_cmd.k_op = not_pkg::K_INC;
                        n_state = S_EV_RD;
                    end
                end
                S_APPEND: begin
                    o_cmd.wsel    = not_pkg::WS_NEW;
                    o_cmd.fill_op = not_pkg::F_INC;
                    if (i_stat.fill_zero) begin
                        n_status = not_pkg::ST_APPEND;
                        n_phase  = P_FIN;
                    end else begin
                        o_cmd.j_op = not_pkg::J_TOP;
                        n_state = S_DP_RD;
                    end
                end
                S_DP_RD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_DP_EV;
                end
                S_DP_EV: begin
                    priority if (i_stat.mn_hit) begin
                        o_cmd.k_op = not_pkg::K_FROM_J;
                        n_state = S_RM_RD;
                    end else if (i_stat.j_zero) begin
                        n_status = not_pkg::ST_APPEND;
                        n_phase  = P_FIN;
                    end else begin
                        o_cmd.j_op = not_pkg::J_DEC;
                        n_state = S_DP_RD;
                    end
                end
                S_RM_RD: begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_k  = 1'b1;
                    n_state = S_RM_EV;
                end
                S_RM_EV: begin
                    o_cmd.wsel = not_pkg::WS_SHIFT;
                    if (i_stat.k_last) begin
                        o_cmd.fill_op = not_pkg::F_DEC;
                        n_status = not_pkg::ST_APPEND;
                        n_phase  = P_FIN;
                    end else begin
                        o_cmd.k_op = not_pkg::K_INC;
                        n_state = S_RM_RD;
                    end
                end
                S_Q_RD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_Q_EV;
                end
                S_Q_EV: begin
                    o_cmd.q_eval = 1'b1;
                    if (i_stat.q_tight) o_cmd.wsel = not_pkg::WS_BEST;
                    if (i_stat.j_zero) begin
                        n_status = (i_stat.found || i_stat.mac_hit) ? not_pkg::ST_FOUND
                                                                    : not_pkg::ST_NONE;
                        n_phase  = P_FIN;
                    end else begin
                        o_cmd.j_op = not_pkg::J_DEC;
                        n_state = S_Q_RD;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_WORK;
            r_status <= not_pkg::ST_NONE;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ----- sv/nearest_observation_table.sv -----
// ============================================================================
// Nearest observation table
// Age-ordered sighting table with add, mark-superseded and nearest query.
// ============================================================================
// Input channel i_in_valid/o_in_ready carries one command word (add, mark,
// query); output channel o_out_valid/i_out_ready returns exactly one result
// word per command. Commands are processed one at a time by a controller
// stepping an entry memory with separate read and write addresses; each
// entry visited takes a read state and then an evaluate state. A query and
// a mark each scan the table once; an add may run a re-report scan, then
// either a mark scan or an eviction shift, an append, a duplicate scan and
// a removal shift. The read state is there because the memory read is registered.
// The result sits in an output register; a new command is taken once the
// previous result is loaded there, even if the receiver has not taken it.
// When the receiver stalls, a finished command waits until the output
// register frees. Reset empties the table (fill count to zero) at once; no
// clearing pass is needed and entry contents stay undefined until written.
// ============================================================================
`default_nettype none

`include "nearest_observation_table_assert.svh"

module nearest_observation_table #(
    parameter int TABLE_DEPTH = not_pkg::TableDepthDefault
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  not_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output not_pkg::t_out_word o_out_word
);

    not_pkg::t_dp_cmd  w_cmd;
    not_pkg::t_dp_stat w_stat;

    not_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    not_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_word      (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    `NOT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready,
        "ready stayed high after a word was accepted")
    `NOT_ASSERT_SAME(a_append_room, i_clk, i_rst_n, w_cmd.fill_op == not_pkg::F_INC,
        !w_stat.fill_full, "append into a full table")
    `NOT_ASSERT_SAME(a_result_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready),
        "result word appeared without a command in work")

endmodule

`default_nettype wire
